// ===== rtl/stepper_homing_sequencer_top_macros.svh =====
// Assertion helpers for the stepper homing sequencer.
// The asserting module must have clk and arst_n in scope.
`ifndef STEPPER_HOMING_SEQUENCER_TOP_MACROS_SVH
`define STEPPER_HOMING_SEQUENCER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must never be seen.
`define SHS_ASSERT_NEVER(lbl, cond, msg) \
	`SHS_ASSERT_IMP(lbl, 1'b1, !(cond), msg)

`endif

// ===== rtl/shs_pkg.sv =====
`default_nettype none
package shs_pkg;

	localparam int STEPS_PER_UNIT = 160;
	localparam int BACKOFF_STEPS  = 500;
	localparam int SEEK_TIMEOUT   = 10000;
	localparam int LIFT_TIMEOUT   = 5000;
	localparam int OPEN_HITS      = 15;
	localparam int CLOSE_HITS     = 10;

	localparam int REG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int OPCODE_W  = 3;
	localparam int UNITS_W   = 8;
	localparam int STATUS_W  = 2;

	localparam int MOVE_MAX  = (2 ** UNITS_W - 1) * STEPS_PER_UNIT + 1;
	localparam int SENSE_MAX = SEEK_TIMEOUT + 2;
	localparam int TOTAL_MAX = (MOVE_MAX > SENSE_MAX) ? MOVE_MAX : SENSE_MAX;
	localparam int TOTAL_W   = $clog2(TOTAL_MAX + 1);

	localparam logic [REG_W-1:0] SEEK_STABLE_RST = 16'd20;
	localparam logic [REG_W-1:0] ROTARY_HALF_RST = 16'd1250;
	localparam logic [REG_W-1:0] LIFT_HALF_RST   = 16'd400;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BACKOFF,
		PH_SEEK,
		PH_OPEN,
		PH_CLOSE,
		PH_MOVE
	} phase_t;

	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK,
		OP_CALIBRATE,
		OP_LIFT_OPEN,
		OP_LIFT_CLOSE,
		OP_MOVE
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_TIMEOUT,
		ST_REJECT
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEEK_STABLE,
		REG_ROTARY_HALF,
		REG_LIFT_HALF
	} reg_index_t;

endpackage
`default_nettype wire

// ===== rtl/stepper_homing_sequencer_top.sv =====
`default_nettype none
// Two-axis stepper sequencer: one item is accepted per clock unless stalled (opcode 0
// is a timebase tick, 1 to 4 start calibrate, lift open, lift close or rotary move)
// and every item yields exactly one result, held in an output register. The whole
// per-item update is a single pass of counters and compares between the input and
// that register, so items flow back to back; in_stall is raised only while the output
// register holds a result that out_stall is holding back. Configuration writes through
// cfg_we, cfg_index and cfg_data take effect at once and are meant for idle periods.
module stepper_homing_sequencer_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [shs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [shs_pkg::REG_W-1:0]      cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [shs_pkg::OPCODE_W-1:0]   opcode,
	input  wire logic [shs_pkg::UNITS_W-1:0]    move_units,
	input  wire logic                           home_sensor,
	input  wire logic                           open_limit,
	input  wire logic                           closed_limit,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                rotary_step,
	output logic                                rotary_direction,
	output logic                                lift_step,
	output logic                                lift_direction,
	output logic                                busy_res,
	output logic                                done_res,
	output logic [shs_pkg::STATUS_W-1:0]        status
);
	import shs_pkg::*;

	logic [REG_W-1:0]   seek_stable_q;
	logic [REG_W-1:0]   rotary_half_q;
	logic [REG_W-1:0]   lift_half_q;

	phase_t             phase_q, phase_d;
	logic [REG_W-1:0]   half_timer_q, half_timer_d;
	logic               step_level_q, step_level_d;
	logic [REG_W-1:0]   stable_count_q, stable_count_d;
	logic [TOTAL_W-1:0] step_total_q, step_total_d;
	logic               rot_dir_q, rot_dir_d;
	logic               lift_dir_q, lift_dir_d;
	logic               done_d;
	status_t            status_d;

	logic               out_valid_q;
	logic               rotary_step_q, rotary_dir_res_q, lift_step_q, lift_dir_res_q;
	logic               busy_q, done_q;
	logic [STATUS_W-1:0] status_q;

	logic               rotary_step_d, lift_step_d, busy_d;

	logic               in_acc;
	logic [REG_W:0]     timer_inc;
	logic [REG_W-1:0]   period;
	logic [TOTAL_W-1:0] total_inc;
	logic [TOTAL_W-1:0] total_dec;
	logic [TOTAL_W-1:0] sense_limit;
	logic [REG_W-1:0]   sense_need;
	logic               sense_hit;
	logic [REG_W-1:0]   stable_inc;
	logic [REG_W-1:0]   stable_next;

	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seek_stable_q <= SEEK_STABLE_RST;
			rotary_half_q <= ROTARY_HALF_RST;
			lift_half_q   <= LIFT_HALF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEEK_STABLE: seek_stable_q <= cfg_data;
				REG_ROTARY_HALF: rotary_half_q <= cfg_data;
				REG_LIFT_HALF:   lift_half_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		period      = (phase_q == PH_OPEN || phase_q == PH_CLOSE) ? lift_half_q : rotary_half_q;
		timer_inc   = {1'b0, half_timer_q} + {{REG_W{1'b0}}, 1'b1};
		total_inc   = step_total_q + TOTAL_W'(1);
		total_dec   = (step_total_q != '0) ? step_total_q - TOTAL_W'(1) : step_total_q;
		stable_inc  = (stable_count_q != '1) ? stable_count_q + REG_W'(1) : stable_count_q;
		case (phase_q)
			PH_OPEN: begin
				sense_hit   = open_limit;
				sense_need  = REG_W'(OPEN_HITS);
				sense_limit = TOTAL_W'(LIFT_TIMEOUT);
			end
			PH_CLOSE: begin
				sense_hit   = closed_limit;
				sense_need  = REG_W'(CLOSE_HITS);
				sense_limit = TOTAL_W'(LIFT_TIMEOUT);
			end
			default: begin
				sense_hit   = home_sensor;
				sense_need  = seek_stable_q;
				sense_limit = TOTAL_W'(SEEK_TIMEOUT);
			end
		endcase
		stable_next = sense_hit ? stable_inc : '0;
	end

	always_comb begin
		phase_d        = phase_q;
		half_timer_d   = half_timer_q;
		step_level_d   = step_level_q;
		stable_count_d = stable_count_q;
		step_total_d   = step_total_q;
		rot_dir_d      = rot_dir_q;
		lift_dir_d     = lift_dir_q;
		done_d         = 1'b0;
		status_d       = ST_OK;
		case (opcode)
			OP_CALIBRATE, OP_LIFT_OPEN, OP_LIFT_CLOSE, OP_MOVE: begin
				if (phase_q != PH_IDLE) begin
					done_d   = 1'b1;
					status_d = ST_REJECT;
				end else if (opcode == OP_LIFT_OPEN && open_limit) begin
					done_d = 1'b1;
				end else if (opcode == OP_LIFT_CLOSE && closed_limit) begin
					done_d = 1'b1;
				end else begin
					half_timer_d   = '0;
					step_level_d   = 1'b1;
					stable_count_d = '0;
					step_total_d   = '0;
					case (opcode)
						OP_CALIBRATE: begin
							rot_dir_d = 1'b1;
							phase_d   = home_sensor ? PH_BACKOFF : PH_SEEK;
						end
						OP_LIFT_OPEN: begin
							lift_dir_d = 1'b1;
							phase_d    = PH_OPEN;
						end
						OP_LIFT_CLOSE: begin
							lift_dir_d = 1'b0;
							phase_d    = PH_CLOSE;
						end
						default: begin
							rot_dir_d    = 1'b1;
							phase_d      = PH_MOVE;
							step_total_d = TOTAL_W'(move_units) * TOTAL_W'(STEPS_PER_UNIT)
								+ TOTAL_W'(1);
						end
					endcase
				end
			end
			OP_TICK: begin
				if (phase_q != PH_IDLE) begin
					half_timer_d = timer_inc[REG_W-1:0];
					if (timer_inc >= {1'b0, period}) begin
						half_timer_d = '0;
						if (!step_level_q) begin
							step_level_d = 1'b1;
						end else begin
							step_level_d = 1'b0;
							case (phase_q)
								PH_BACKOFF: begin
									if (total_inc > TOTAL_W'(BACKOFF_STEPS)) begin
										phase_d        = PH_SEEK;
										step_total_d   = '0;
										stable_count_d = '0;
									end else begin
										step_total_d = total_inc;
									end
								end
								PH_SEEK, PH_OPEN, PH_CLOSE: begin
									step_total_d   = total_inc;
									stable_count_d = stable_next;
									if (step_total_q > sense_limit) begin
										phase_d  = PH_IDLE;
										done_d   = 1'b1;
										status_d = ST_TIMEOUT;
									end else if (stable_next > sense_need) begin
										phase_d = PH_IDLE;
										done_d  = 1'b1;
									end
								end
								PH_MOVE: begin
									step_total_d = total_dec;
									if (total_dec == '0) begin
										phase_d = PH_IDLE;
										done_d  = 1'b1;
									end
								end
								default: ;
							endcase
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		busy_d        = (phase_d != PH_IDLE);
		rotary_step_d = step_level_d && busy_d
			&& (phase_d == PH_BACKOFF || phase_d == PH_SEEK || phase_d == PH_MOVE);
		lift_step_d   = step_level_d && (phase_d == PH_OPEN || phase_d == PH_CLOSE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			half_timer_q   <= '0;
			step_level_q   <= 1'b0;
			stable_count_q <= '0;
			step_total_q   <= '0;
			rot_dir_q      <= 1'b0;
			lift_dir_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (in_acc) begin
				phase_q        <= phase_d;
				half_timer_q   <= (phase_d == PH_IDLE) ? '0 : half_timer_d;
				step_level_q   <= (phase_d == PH_IDLE) ? 1'b0 : step_level_d;
				stable_count_q <= stable_count_d;
				step_total_q   <= step_total_d;
				rot_dir_q      <= rot_dir_d;
				lift_dir_q     <= lift_dir_d;
				out_valid_q    <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rotary_step_q    <= rotary_step_d;
			rotary_dir_res_q <= rot_dir_d;
			lift_step_q      <= lift_step_d;
			lift_dir_res_q   <= lift_dir_d;
			busy_q           <= busy_d;
			done_q           <= done_d;
			status_q         <= done_d ? status_d : ST_OK;
		end
	end

	assign out_valid        = out_valid_q;
	assign rotary_step      = rotary_step_q;
	assign rotary_direction = rotary_dir_res_q;
	assign lift_step        = lift_step_q;
	assign lift_direction   = lift_dir_res_q;
	assign busy_res         = busy_q;
	assign done_res         = done_q;
	assign status           = status_q;

endmodule
`default_nettype wire

// ===== rtl/shs_checker.sv =====
`default_nettype none
`include "stepper_homing_sequencer_top_macros.svh"
module shs_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_stall,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic                         rotary_step,
	input wire logic                         lift_step,
	input wire logic                         busy_res,
	input wire logic                         done_res,
	input wire logic [shs_pkg::STATUS_W-1:0] status
);
	import shs_pkg::*;

	`SHS_ASSERT_IMP(a_stall_only_when_full, in_stall, out_valid && out_stall, "input stalled without a held result")
	`SHS_ASSERT_IMP(a_status_needs_done, out_valid && !done_res, status == ST_OK, "status set without done")
	`SHS_ASSERT_IMP(a_reject_while_busy, out_valid && done_res && status == ST_REJECT, busy_res, "reject reported while idle")
	`SHS_ASSERT_IMP(a_step_needs_busy, out_valid && (rotary_step || lift_step), busy_res, "step level shown while idle")
	`SHS_ASSERT_NEVER(a_one_axis_steps, out_valid && rotary_step && lift_step, "both axes stepping at once")

endmodule

bind stepper_homing_sequencer_top shs_checker u_shs_checker (.*);
`default_nettype wire
